/* rtl/tpcs_pkg.sv */
`default_nettype none

package tpcs_pkg;

  localparam int DIAL_POSITIONS = 12;
  localparam int DIAL_W = $clog2(DIAL_POSITIONS);
  localparam logic [DIAL_W-1:0] DIAL_MAX = DIAL_W'(DIAL_POSITIONS - 1);

  localparam int CFG_INDEX_W = 8;
  localparam int CFG_DATA_W = 16;

  localparam logic [CFG_INDEX_W-1:0] REG_TICKS_PER_SECOND = 8'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_IDLE_TIMEOUT_TICKS = 8'd1;

  localparam logic [15:0] TICKS_PER_SECOND_RESET = 16'd100;
  localparam logic [15:0] IDLE_TIMEOUT_RESET = 16'd500;

  localparam logic [1:0] MODE_RUN = 2'd0;
  localparam logic [1:0] MODE_HOUR = 2'd1;
  localparam logic [1:0] MODE_MINUTE = 2'd2;

  localparam logic [2:0] BTN_MODE = 3'b001;
  localparam logic [2:0] BTN_UP = 3'b010;
  localparam logic [2:0] BTN_DOWN = 3'b100;

  typedef struct packed {
    logic [2:0] buttons_pressed;
    logic [2:0] buttons_armed;
  } tick_in_t;

  typedef struct packed {
    logic [1:0] mode_now;
    logic [3:0] hour_value;
    logic [3:0] minute_value;
    logic [3:0] second_value;
    logic       show_hour;
    logic       show_minute;
    logic       show_second;
    logic [2:0] rearm_buttons;
  } tick_out_t;

  function automatic logic [DIAL_W-1:0] dial_up(input logic [DIAL_W-1:0] v);
    dial_up = (v >= DIAL_MAX) ? '0 : v + 1'b1;
  endfunction

  function automatic logic [DIAL_W-1:0] dial_down(input logic [DIAL_W-1:0] v);
    dial_down = (v == '0) ? DIAL_MAX : v - 1'b1;
  endfunction

endpackage

`default_nettype wire

/* rtl/twelve_position_clock_setter.sv */
// Dial clock with hour-set and minute-set modes.
// Input channel (in_valid, in_stall, in_data): one transaction per tick, carrying
// the button levels and the repeat-armed flags. Output channel (out_valid,
// out_stall, out_data): exactly one result per tick, in order: mode, the three
// dial counters, the display flags and the rearm request (one-hot or zero).
// Configuration channel (cfg_valid, cfg_ready, cfg_index, cfg_data): index 0 sets
// ticks per second, index 1 the idle timeout; other indexes are ignored.
// cfg_ready is always high; write only while no tick is in flight.
// The state registers and the result are written at the edge that accepts the
// tick; the result goes to the output register, or to the skid register while
// a result waits there. One tick per cycle is sustained while results are taken.
// An output register backed by a one-entry skid register lets a tick be taken
// while a result waits; in_stall rises only when both hold a result, so a
// stalled receiver costs at most two buffered results before the input backs up.
// Reset (synchronous, rst_n low) returns run mode, zero counters, the prescaler
// at 100, the idle count at 0, the register defaults and empty buffers.
`default_nettype none

module twelve_position_clock_setter
  import tpcs_pkg::*;
(
  input  wire logic                   clk,
  input  wire logic                   rst_n,
  input  wire logic                   in_valid,
  output logic                        in_stall,
  input  wire tick_in_t               in_data,
  output logic                        out_valid,
  input  wire logic                   out_stall,
  output tick_out_t                   out_data,
  input  wire logic                   cfg_valid,
  output logic                        cfg_ready,
  input  wire logic [CFG_INDEX_W-1:0] cfg_index,
  input  wire logic [CFG_DATA_W-1:0]  cfg_data
);

  logic [15:0]       ticks_per_second_r;
  logic [15:0]       idle_timeout_r;
  logic [1:0]        mode_r, mode_nxt;
  logic [DIAL_W-1:0] hour_r, hour_nxt;
  logic [DIAL_W-1:0] minute_r, minute_nxt;
  logic [DIAL_W-1:0] second_r, second_nxt;
  logic [15:0]       prescale_r, prescale_nxt;
  logic [15:0]       idle_r, idle_nxt;

  logic              out_valid_r;
  tick_out_t         out_data_r;
  logic              skid_valid_r;
  tick_out_t         skid_data_r;

  logic              in_fire;
  logic              out_fire;
  logic [2:0]        usable;
  logic [2:0]        used;
  logic              sh, sm, ss;
  tick_out_t         result;

  assign cfg_ready = 1'b1;
  assign in_stall  = skid_valid_r;
  assign in_fire   = in_valid && !skid_valid_r;
  assign out_fire  = out_valid_r && !out_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  always_comb begin
    usable     = in_data.buttons_pressed & in_data.buttons_armed;
    used       = '0;
    mode_nxt   = mode_r;
    hour_nxt   = hour_r;
    minute_nxt = minute_r;
    second_nxt = second_r;
    prescale_nxt = prescale_r;
    idle_nxt   = idle_r;
    sh = 1'b1;
    sm = 1'b1;
    ss = 1'b1;

    case (mode_r)
      MODE_HOUR: begin
        if (usable[0]) begin
          mode_nxt = MODE_MINUTE;
          used = BTN_MODE;
        end else if (usable[1]) begin
          hour_nxt = dial_up(hour_r);
          used = BTN_UP;
        end else if (usable[2]) begin
          hour_nxt = dial_down(hour_r);
          used = BTN_DOWN;
        end
        sm = 1'b0;
        ss = 1'b0;
      end
      MODE_MINUTE: begin
        if (usable[1]) begin
          minute_nxt = dial_up(minute_r);
          used = BTN_UP;
        end else if (usable[2]) begin
          minute_nxt = dial_down(minute_r);
          used = BTN_DOWN;
        end
        sh = 1'b0;
        ss = 1'b0;
      end
      default: begin
        if (usable[0]) begin
          mode_nxt = MODE_HOUR;
          used = BTN_MODE;
        end
        // The seconds carry into minutes and hours only when each wraps to zero.
        if (prescale_r <= 16'd1) begin
          prescale_nxt = ticks_per_second_r;
          second_nxt = dial_up(second_r);
          if (second_nxt == '0) begin
            minute_nxt = dial_up(minute_r);
            if (minute_nxt == '0) begin
              hour_nxt = dial_up(hour_r);
            end
          end
        end else begin
          prescale_nxt = prescale_r - 16'd1;
        end
      end
    endcase

    if (used != '0) begin
      idle_nxt = idle_timeout_r;
    end

    // The timeout runs only on fully released ticks and saturates at zero.
    if (in_data.buttons_pressed == '0) begin
      if (idle_nxt != '0) begin
        idle_nxt = idle_nxt - 16'd1;
      end
      if (idle_nxt == '0) begin
        mode_nxt = MODE_RUN;
      end
    end

    result.mode_now      = mode_nxt;
    result.hour_value    = 4'(hour_nxt);
    result.minute_value  = 4'(minute_nxt);
    result.second_value  = 4'(second_nxt);
    result.show_hour     = sh;
    result.show_minute   = sm;
    result.show_second   = ss;
    result.rearm_buttons = used;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ticks_per_second_r <= TICKS_PER_SECOND_RESET;
      idle_timeout_r     <= IDLE_TIMEOUT_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_TICKS_PER_SECOND:   ticks_per_second_r <= cfg_data;
        REG_IDLE_TIMEOUT_TICKS: idle_timeout_r     <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_RUN;
      hour_r     <= '0;
      minute_r   <= '0;
      second_r   <= '0;
      prescale_r <= TICKS_PER_SECOND_RESET;
      idle_r     <= '0;
    end else if (in_fire) begin
      mode_r     <= mode_nxt;
      hour_r     <= hour_nxt;
      minute_r   <= minute_nxt;
      second_r   <= second_nxt;
      prescale_r <= prescale_nxt;
      idle_r     <= idle_nxt;
    end
  end

  // The skid register is empty whenever a tick is accepted, since in_stall
  // follows it directly.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        if (!out_valid_r || out_fire) begin
          out_valid_r <= 1'b1;
        end else begin
          skid_valid_r <= 1'b1;
        end
      end else if (out_fire) begin
        if (skid_valid_r) begin
          skid_valid_r <= 1'b0;
        end else begin
          out_valid_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      if (!out_valid_r || out_fire) begin
        out_data_r <= result;
      end else begin
        skid_data_r <= result;
      end
    end else if (out_fire && skid_valid_r) begin
      out_data_r <= skid_data_r;
    end
  end

endmodule

`default_nettype wire

/* rtl/tpcs_checker.sv */
`default_nettype none

module tpcs_checker
  import tpcs_pkg::*;
(
  input wire logic      clk,
  input wire logic      rst_n,
  input wire logic      out_valid,
  input wire logic      out_stall,
  input wire tick_out_t out_data
);

  // A result held back by the receiver stays in place.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_rearm_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $onehot0(out_data.rearm_buttons))
    else $error("more than one button rearmed in one transaction");

  a_mode_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_data.mode_now != 2'd3)
    else $error("unused mode code reported");

  a_run_display: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.show_second |-> out_data.show_hour && out_data.show_minute)
    else $error("run display must show all three dials");

  a_set_display: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.show_second |-> out_data.show_hour != out_data.show_minute)
    else $error("set display must show exactly one dial");

endmodule

bind twelve_position_clock_setter tpcs_checker u_tpcs_checker (.*);

`default_nettype wire

/* test/clock_setter_checker.sv */
`timescale 1ns / 100ps

module clock_setter_checker
  import tpcs_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  tick_in_t               in_data,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  tick_out_t              out_data,
  input  logic                   cfg_valid,
  input  logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     fail_count,
  output int                     pending
);

  localparam logic [3:0] DIAL_TOP = 4'(DIAL_POSITIONS - 1);

  logic [1:0]  mode_s;
  logic [3:0]  hour_s;
  logic [3:0]  minute_s;
  logic [3:0]  second_s;
  logic [15:0] prescale_s;
  logic [15:0] idle_s;
  logic [15:0] tps_s;
  logic [15:0] timeout_s;
  tick_out_t   expected_ticks[$];
  int          errors_seen = 0;

  function automatic logic [3:0] dial_wrap(input logic [3:0] v, input bit up);
    if (up) begin
      return (v >= DIAL_TOP) ? 4'd0 : v + 4'd1;
    end
    return (v == 4'd0) ? DIAL_TOP : v - 4'd1;
  endfunction

  // Advances the clock state by one tick and returns the display it produces.
  function automatic tick_out_t clock_tick(input tick_in_t t);
    tick_out_t  r;
    logic [2:0] usable;
    logic [1:0] start_mode;
    usable = t.buttons_pressed & t.buttons_armed;
    start_mode = mode_s;
    r = '0;
    case (start_mode)
      MODE_HOUR: begin
        if (|(usable & BTN_MODE)) begin
          mode_s = MODE_MINUTE;
          r.rearm_buttons = BTN_MODE;
        end else if (|(usable & BTN_UP)) begin
          hour_s = dial_wrap(hour_s, 1'b1);
          r.rearm_buttons = BTN_UP;
        end else if (|(usable & BTN_DOWN)) begin
          hour_s = dial_wrap(hour_s, 1'b0);
          r.rearm_buttons = BTN_DOWN;
        end
        r.show_hour = 1'b1;
      end
      MODE_MINUTE: begin
        // The mode button has no effect here; only the timeout leaves.
        if (|(usable & BTN_UP)) begin
          minute_s = dial_wrap(minute_s, 1'b1);
          r.rearm_buttons = BTN_UP;
        end else if (|(usable & BTN_DOWN)) begin
          minute_s = dial_wrap(minute_s, 1'b0);
          r.rearm_buttons = BTN_DOWN;
        end
        r.show_minute = 1'b1;
      end
      default: begin
        if (|(usable & BTN_MODE)) begin
          mode_s = MODE_HOUR;
          r.rearm_buttons = BTN_MODE;
        end
        // The clock still advances on the tick that leaves run mode.
        if (prescale_s <= 16'd1) begin
          prescale_s = tps_s;
          second_s = dial_wrap(second_s, 1'b1);
          if (second_s == 4'd0) begin
            minute_s = dial_wrap(minute_s, 1'b1);
            if (minute_s == 4'd0) begin
              hour_s = dial_wrap(hour_s, 1'b1);
            end
          end
        end else begin
          prescale_s = prescale_s - 16'd1;
        end
        r.show_hour = 1'b1;
        r.show_minute = 1'b1;
        r.show_second = 1'b1;
      end
    endcase
    if (r.rearm_buttons != 3'b000) begin
      idle_s = timeout_s;
    end
    if (t.buttons_pressed == 3'b000) begin
      if (idle_s != 16'd0) begin
        idle_s = idle_s - 16'd1;
      end
      if (idle_s == 16'd0) begin
        mode_s = MODE_RUN;
      end
    end
    r.mode_now = mode_s;
    r.hour_value = hour_s;
    r.minute_value = minute_s;
    r.second_value = second_s;
    return r;
  endfunction

  always @(posedge clk) begin : monitor
    tick_out_t got;
    tick_out_t want;
    if (!rst_n) begin
      mode_s = MODE_RUN;
      hour_s = 4'd0;
      minute_s = 4'd0;
      second_s = 4'd0;
      prescale_s = TICKS_PER_SECOND_RESET;
      idle_s = 16'd0;
      tps_s = TICKS_PER_SECOND_RESET;
      timeout_s = IDLE_TIMEOUT_RESET;
      expected_ticks.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_TICKS_PER_SECOND: tps_s = cfg_data;
          REG_IDLE_TIMEOUT_TICKS: timeout_s = cfg_data;
          default: ;
        endcase
      end
      // A result cannot come from the tick accepted at this same edge,
      // so results are checked before the new expectation is queued.
      if (out_valid && !out_stall) begin
        got = out_data;
        if (expected_ticks.size() == 0) begin
          errors_seen++;
          if (errors_seen <= 10) begin
            $display("%0t: result with no tick outstanding: %p", $realtime, got);
          end
        end else begin
          want = expected_ticks.pop_front();
          if (got.mode_now !== want.mode_now || got.hour_value !== want.hour_value ||
              got.minute_value !== want.minute_value ||
              got.second_value !== want.second_value ||
              got.show_hour !== want.show_hour || got.show_minute !== want.show_minute ||
              got.show_second !== want.show_second ||
              got.rearm_buttons !== want.rearm_buttons) begin
            errors_seen++;
            if (errors_seen <= 10) begin
              $display("%0t: mismatch", $realtime);
              $display("  expected mode %0d time %0d:%0d:%0d show %b%b%b rearm %b",
                       want.mode_now, want.hour_value, want.minute_value, want.second_value,
                       want.show_hour, want.show_minute, want.show_second,
                       want.rearm_buttons);
              $display("  actual   mode %0d time %0d:%0d:%0d show %b%b%b rearm %b",
                       got.mode_now, got.hour_value, got.minute_value, got.second_value,
                       got.show_hour, got.show_minute, got.show_second,
                       got.rearm_buttons);
            end
          end
        end
      end
      if (in_valid && !in_stall) begin
        expected_ticks.push_back(clock_tick(in_data));
      end
    end
    fail_count <= errors_seen;
    pending <= expected_ticks.size();
  end

endmodule

/* test/tb_twelve_position_clock_setter.sv */
`timescale 1ns / 100ps

module tb_twelve_position_clock_setter;
  import tpcs_pkg::*;

  // No register lives at this index; writes to it must be dropped.
  localparam logic [CFG_INDEX_W-1:0] REG_UNMAPPED = 8'd9;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_valid = 1'b0;
  logic                   in_stall;
  tick_in_t               in_data = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  tick_out_t              out_data;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  int          fail_count;
  int          pending;
  int          ticks_sent = 0;
  bit          sender_busy_run = 1'b0;
  bit          sink_busy_run = 1'b0;
  logic [15:0] timeout_now = IDLE_TIMEOUT_RESET;

  always #6 clk = ~clk;

  twelve_position_clock_setter u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  clock_setter_checker u_check (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_data    (in_data),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_data   (out_data),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .fail_count (fail_count),
    .pending    (pending)
  );

  // Randomly holds off results with out_stall, with occasional runs that never stall.
  initial begin : result_sink
    int hold;
    forever begin
      if ($urandom_range(0, 63) == 0) begin
        sink_busy_run = !sink_busy_run;
      end
      hold = sink_busy_run ? 0 : $urandom_range(0, 15);
      if (hold != 0) begin
        out_stall <= 1'b1;
        repeat (hold) @(posedge clk);
        out_stall <= 1'b0;
      end
      @(posedge clk);
      while (!out_valid) @(posedge clk);
    end
  end

  // Called at a rising edge; returns at the edge that accepts the transaction.
  task automatic send_tick(input logic [2:0] pressed, input logic [2:0] armed);
    int gap;
    if ($urandom_range(0, 63) == 0) begin
      sender_busy_run = !sender_busy_run;
    end
    gap = sender_busy_run ? 0 : $urandom_range(0, 15);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= tick_in_t'{buttons_pressed: pressed, buttons_armed: armed};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    ticks_sent++;
  endtask

  task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx, input logic [15:0] value);
    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (2) @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= value;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    cfg_valid <= 1'b0;
    if (idx == REG_IDLE_TIMEOUT_TICKS) begin
      timeout_now = value;
    end
  endtask

  // The given button, armed most of the time, with random noise on the other flags.
  function automatic logic [2:0] arm_mostly(input logic [2:0] btn);
    logic [2:0] noise;
    noise = 3'($urandom_range(0, 7)) & ~btn;
    return (($urandom_range(0, 3) != 0) ? btn : 3'b000) | noise;
  endfunction

  task automatic release_buttons(input int n);
    repeat (n) send_tick(3'b000, 3'($urandom_range(0, 7)));
  endtask

  task automatic press_mode();
    logic [2:0] extra;
    extra = ($urandom_range(0, 3) == 0) ? 3'($urandom_range(0, 7)) : 3'b000;
    send_tick(BTN_MODE | extra, arm_mostly(BTN_MODE) | extra);
  endtask

  // Up and down steps, held buttons and short releases that stay under the timeout.
  task automatic adjust_dial(input int n);
    int spare;
    repeat (n) begin
      case ($urandom_range(0, 7))
        0, 1, 2: send_tick(BTN_UP, arm_mostly(BTN_UP));
        3, 4, 5: send_tick(BTN_DOWN, arm_mostly(BTN_DOWN));
        6: send_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
        default: begin
          spare = (timeout_now > 16'd6) ? 5 : int'(timeout_now) - 1;
          if (spare > 0) begin
            release_buttons($urandom_range(1, spare));
          end
        end
      endcase
    end
  endtask

  // Run for a while, set hour and minute, then release, often until the timeout.
  task automatic set_session();
    int release_len;
    if ($urandom_range(0, 3) == 0) begin
      release_buttons($urandom_range(20, 160));
    end else begin
      repeat ($urandom_range(0, 6)) send_tick(3'($urandom_range(0, 7)), 3'($urandom_range(0, 7)));
    end
    press_mode();
    adjust_dial($urandom_range(1, 12));
    press_mode();
    adjust_dial($urandom_range(1, 12));
    if (timeout_now <= 16'd600) begin
      release_len = int'(timeout_now) + $urandom_range(0, 2);
    end else begin
      release_len = $urandom_range(0, 40);
    end
    if ($urandom_range(0, 4) == 0) begin
      release_len = $urandom_range(0, release_len);
    end
    release_buttons(release_len);
  endtask

  task automatic run_sessions(input int n);
    int target;
    target = ticks_sent + n;
    while (ticks_sent < target) set_session();
  endtask

  task automatic configure(input logic [15:0] tps, input logic [15:0] timeout);
    write_reg(REG_TICKS_PER_SECOND, tps);
    write_reg(REG_IDLE_TIMEOUT_TICKS, timeout);
  endtask

  initial begin : stimulus
    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Run mode: idle, pressed but not armed, and the set buttons ignored.
    send_tick(3'b000, 3'b000);
    send_tick(3'b111, 3'b000);
    send_tick(BTN_UP | BTN_DOWN, BTN_UP | BTN_DOWN);
    // All buttons usable: the mode button wins and the clock still advances.
    send_tick(3'b111, 3'b111);
    // Hour set: wrap down and up, up beats down, unarmed down does nothing.
    send_tick(BTN_DOWN, BTN_DOWN);
    send_tick(BTN_UP, BTN_UP);
    send_tick(BTN_UP | BTN_DOWN, 3'b111);
    send_tick(BTN_DOWN, BTN_MODE | BTN_UP);
    send_tick(3'b000, 3'b111);
    send_tick(3'b111, 3'b111);
    // Minute set: the mode button is ignored, up and down wrap.
    send_tick(BTN_MODE, BTN_MODE);
    send_tick(BTN_DOWN, BTN_DOWN);
    send_tick(BTN_UP, BTN_UP);
    send_tick(3'b111, 3'b111);
    send_tick(BTN_MODE | BTN_DOWN, BTN_MODE | BTN_DOWN);
    send_tick(3'b000, 3'b000);

    // A session at the default timeout usually runs past five hundred ticks.
    run_sessions(250);
    configure(16'd1, 16'd1);
    run_sessions(200);
    write_reg(REG_UNMAPPED, 16'hFFFF);
    configure(16'd0, 16'd0);
    run_sessions(200);
    configure(16'd3, 16'd6);
    run_sessions(180);
    configure(16'd2, 16'd13);
    run_sessions(180);
    configure(16'hFFFF, 16'hFFFF);
    run_sessions(100);
    configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)));
    run_sessions(120);
    configure(16'($urandom_range(1, 40)), 16'($urandom_range(1, 30)));
    run_sessions(120);

    in_valid <= 1'b0;
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
    if (fail_count == 0 && pending == 0) begin
      $display("tb_twelve_position_clock_setter: clean");
    end else begin
      $display("tb_twelve_position_clock_setter: errors");
    end
    $finish;
  end

  initial begin : watchdog
    #8_000_000;
    $display("tb_twelve_position_clock_setter: errors");
    $finish;
  end

endmodule
